// File: design/lav_pkg.sv
package lav_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int D_W       = IN_W + 1;
    localparam int UNIT_W    = FRAC_BITS + 2;
    localparam int PROD_W    = UNIT_W + IN_W;
    localparam int VEC_W     = PROD_W + 1;
    localparam int MAG_W     = VEC_W;
    localparam int TOP_BIT   = 29;
    localparam int M_W       = TOP_BIT + 1;
    localparam int SQ_W      = 2 * M_W + 2;
    localparam int LEN_W     = M_W + 1;
    localparam int NUM_W     = M_W + FRAC_BITS + 1;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(Q_W + 1);
    localparam int DOT_W     = PROD_W + 2;
    localparam int QM_W      = DOT_W + 1 - FRAC_BITS;
    localparam int COARSE    = 8;

    typedef logic [IN_W-1:0]  coord_t;
    typedef coord_t [2:0]     coord_vec_t;
    typedef logic [D_W-1:0]   diff_t;
    typedef diff_t [2:0]      diff_vec_t;
    typedef logic [UNIT_W-1:0] unit_t;
    typedef unit_t [2:0]      unit_vec_t;
    typedef logic [VEC_W-1:0] wide_t;
    typedef wide_t [2:0]      wide_vec_t;

    typedef struct packed {
        coord_vec_t pos;
        diff_vec_t  diff;
        coord_vec_t hint;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic      done;
        logic      nonzero;
        unit_vec_t unit;
    } norm_res_t;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_SHIFT,
        NS_SQUARE,
        NS_SUM,
        NS_ROOT,
        NS_DIV_INIT,
        NS_DIVIDE,
        NS_DONE
    } norm_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_NORM_GO,
        BK_NORM_WAIT,
        BK_CROSS_MUL,
        BK_CROSS_SUB,
        BK_DOT_MUL,
        BK_DOT_SUM,
        BK_EMIT
    } back_state_t;

    typedef enum logic [1:0] {
        PASS_FWD,
        PASS_RIGHT,
        PASS_UP
    } pass_t;

    localparam logic [1:0] ROW_LAST = 2'd3;
    localparam logic [1:0] ROW_FWD  = 2'd2;

endpackage

// File: design/lav_front.sv
module lav_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  lav_pkg::coord_vec_t  pos,
    input  lav_pkg::coord_vec_t  tgt,
    input  lav_pkg::coord_vec_t  hint,
    output lav_pkg::queue_head_t head,
    input  logic                 pop
);
    import lav_pkg::*;

    item_t      entry_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       take;
    item_t      new_item;

    assign item_stall = (count_reg == 2'd2);
    assign push       = item_valid && !item_stall;
    assign take       = pop && (count_reg != 2'd0);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            new_item.pos[i]  = pos[i];
            new_item.hint[i] = hint[i];
            new_item.diff[i] = {tgt[i][IN_W-1], tgt[i]} - {pos[i][IN_W-1], pos[i]};
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

// File: design/lav_norm.sv
module lav_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  lav_pkg::wide_vec_t vec_in,
    output lav_pkg::norm_res_t res
);
    import lav_pkg::*;

    norm_state_t          state_reg;
    norm_state_t          state_next;
    logic [MAG_W-1:0]     mag_reg [0:2];
    logic [2:0]           neg_reg;
    logic [2*M_W-1:0]     sq_reg [0:2];
    logic [SQ_W-1:0]      x_reg;
    logic [SQ_W-1:0]      root_reg;
    logic [SQ_W-1:0]      bit_reg;
    logic [NUM_W-1:0]     rem_reg [0:2];
    logic [NUM_W-1:0]     dvs_reg;
    logic [Q_W-1:0]       quo_reg [0:2];
    logic [CNT_W-1:0]     cnt_reg;
    logic                 nz_reg;

    logic [MAG_W-1:0]     in_mag [0:2];
    logic                 in_zero;
    logic [MAG_W-1:0]     orv;
    logic                 shr_coarse;
    logic                 shr_fine;
    logic                 shl_coarse;
    logic                 shl_fine;
    logic [SQ_W:0]        trial;
    logic                 root_ge;
    logic [LEN_W-1:0]     len;
    logic [UNIT_W-1:0]    comp [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_mag[i] = vec_in[i][VEC_W-1] ? (~vec_in[i] + 1'b1) : vec_in[i];
        end
        in_zero = (in_mag[0] == '0) && (in_mag[1] == '0) && (in_mag[2] == '0);
        orv        = mag_reg[0] | mag_reg[1] | mag_reg[2];
        shr_coarse = |orv[MAG_W-1:TOP_BIT+1+COARSE];
        shr_fine   = |orv[MAG_W-1:TOP_BIT+1];
        shl_coarse = ~|orv[MAG_W-1:TOP_BIT-COARSE];
        shl_fine   = ~|orv[MAG_W-1:TOP_BIT];
        trial      = {1'b0, root_reg} + {1'b0, bit_reg};
        root_ge    = ({1'b0, x_reg} >= trial);
        len        = root_reg[LEN_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            NS_IDLE:
            begin
                if (start)
                begin
                    state_next = in_zero ? NS_DONE : NS_SHIFT;
                end
            end
            NS_SHIFT:
            begin
                if (!shr_fine && !shl_fine)
                begin
                    state_next = NS_SQUARE;
                end
            end
            NS_SQUARE:   state_next = NS_SUM;
            NS_SUM:      state_next = NS_ROOT;
            NS_ROOT:
            begin
                if (bit_reg[0])
                begin
                    state_next = NS_DIV_INIT;
                end
            end
            NS_DIV_INIT: state_next = NS_DIVIDE;
            NS_DIVIDE:
            begin
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    state_next = NS_DONE;
                end
            end
            NS_DONE:     state_next = NS_IDLE;
            default:     state_next = NS_IDLE;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            comp[i] = {1'b0, quo_reg[i]};
            res.unit[i] = neg_reg[i] ? (~comp[i] + 1'b1) : comp[i];
        end
        res.done    = (state_reg == NS_DONE);
        res.nonzero = nz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= NS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            NS_IDLE:
            begin
                if (start)
                begin
                    nz_reg <= !in_zero;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= in_mag[i];
                        neg_reg[i] <= vec_in[i][VEC_W-1];
                        quo_reg[i] <= '0;
                    end
                end
            end
            NS_SHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (shr_coarse)
                    begin
                        mag_reg[i] <= mag_reg[i] >> COARSE;
                    end
                    else if (shr_fine)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (shl_coarse)
                    begin
                        mag_reg[i] <= mag_reg[i] << COARSE;
                    end
                    else if (shl_fine)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            NS_SQUARE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[i] <= mag_reg[i][M_W-1:0] * mag_reg[i][M_W-1:0];
                end
            end
            NS_SUM:
            begin
                x_reg    <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
                root_reg <= '0;
                bit_reg  <= SQ_W'(1) << (SQ_W - 2);
            end
            NS_ROOT:
            begin
                if (root_ge)
                begin
                    x_reg    <= x_reg - trial[SQ_W-1:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            NS_DIV_INIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= NUM_W'({mag_reg[i][M_W-1:0], {FRAC_BITS{1'b0}}})
                                + NUM_W'(len >> 1);
                end
                dvs_reg <= NUM_W'({len, {FRAC_BITS{1'b0}}});
                cnt_reg <= '0;
            end
            NS_DIVIDE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[i] >= dvs_reg)
                    begin
                        rem_reg[i] <= rem_reg[i] - dvs_reg;
                        quo_reg[i] <= {quo_reg[i][Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_reg[i] <= {quo_reg[i][Q_W-2:0], 1'b0};
                    end
                end
                dvs_reg <= dvs_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: design/lav_back.sv
module lav_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lav_pkg::queue_head_t head,
    output logic                 pop,
    output logic                 row_valid,
    input  logic                 row_stall,
    output logic [1:0]           row_index,
    output lav_pkg::coord_t      col0,
    output lav_pkg::coord_t      col1,
    output lav_pkg::coord_t      col2,
    output lav_pkg::coord_t      col3,
    output logic                 degenerate,
    output logic                 last_row
);
    import lav_pkg::*;

    back_state_t             state_reg;
    back_state_t             state_next;
    pass_t                   pass_reg;
    logic [1:0]              row_reg;
    logic                    degen_reg;
    logic                    row_valid_reg;

    coord_vec_t              pos_reg;
    coord_vec_t              hint_reg;
    unit_vec_t               f_reg;
    unit_vec_t               r_reg;
    unit_vec_t               u_reg;
    wide_vec_t               vec_reg;
    logic signed [PROD_W-1:0] prod_reg [0:5];
    coord_t                  trans_reg [0:2];
    logic [1:0]              row_index_reg;
    coord_t                  col_reg [0:3];
    logic                    degenerate_reg;
    logic                    last_row_reg;

    logic                    norm_start;
    norm_res_t               nres;
    logic                    load_row;
    logic signed [UNIT_W-1:0] ca [0:2];
    logic signed [IN_W-1:0]  cb [0:2];
    logic signed [UNIT_W-1:0] da [0:2];
    logic signed [IN_W-1:0]  dp [0:2];
    logic signed [PROD_W-1:0] cprod [0:5];
    logic signed [PROD_W-1:0] dprod [0:2];
    logic signed [DOT_W-1:0] dsum;
    logic                    dneg;
    logic [DOT_W-1:0]        dmag;
    logic [DOT_W:0]          rounded;
    logic [QM_W-1:0]         qm;
    logic                    sat;
    logic                    flip;
    coord_t                  tval;
    coord_t                  nc [0:3];

    lav_norm u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .vec_in (vec_reg),
        .res    (nres)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (pass_reg == PASS_FWD)
            begin
                ca[i] = $signed(f_reg[i]);
                cb[i] = $signed(hint_reg[i]);
            end
            else
            begin
                ca[i] = $signed(r_reg[i]);
                cb[i] = IN_W'($signed(f_reg[i]));
            end
            case (row_reg)
                2'd0:    da[i] = $signed(r_reg[i]);
                2'd1:    da[i] = $signed(u_reg[i]);
                default: da[i] = $signed(f_reg[i]);
            endcase
            dp[i]    = $signed(pos_reg[i]);
            dprod[i] = da[i] * dp[i];
        end
        cprod[0] = ca[1] * cb[2];
        cprod[1] = ca[2] * cb[1];
        cprod[2] = ca[2] * cb[0];
        cprod[3] = ca[0] * cb[2];
        cprod[4] = ca[0] * cb[1];
        cprod[5] = ca[1] * cb[0];
    end

    always_comb
    begin
        dsum    = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1]) + DOT_W'(prod_reg[2]);
        dneg    = dsum[DOT_W-1];
        dmag    = dneg ? (~dsum + 1'b1) : dsum;
        rounded = {1'b0, dmag} + ((DOT_W+1)'(1) << (FRAC_BITS - 1));
        qm      = QM_W'(rounded >> FRAC_BITS);
        sat     = |qm[QM_W-1:IN_W-1];
        flip    = dneg ^ (row_reg != ROW_FWD);
        if (sat)
        begin
            tval = flip ? {1'b1, {(IN_W-1){1'b0}}} : {1'b0, {(IN_W-1){1'b1}}};
        end
        else
        begin
            tval = flip ? (~qm[IN_W-1:0] + 1'b1) : qm[IN_W-1:0];
        end
    end

    always_comb
    begin
        case (row_reg)
            2'd0:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    nc[i] = IN_W'($signed(r_reg[i]));
                end
                nc[3] = trans_reg[0];
            end
            2'd1:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    nc[i] = IN_W'($signed(u_reg[i]));
                end
                nc[3] = trans_reg[1];
            end
            2'd2:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    nc[i] = -IN_W'($signed(f_reg[i]));
                end
                nc[3] = trans_reg[2];
            end
            default:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    nc[i] = '0;
                end
                nc[3] = IN_W'(1) << FRAC_BITS;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = BK_NORM_GO;
                end
            end
            BK_NORM_GO:   state_next = BK_NORM_WAIT;
            BK_NORM_WAIT:
            begin
                if (nres.done)
                begin
                    state_next = (pass_reg == PASS_UP) ? BK_DOT_MUL : BK_CROSS_MUL;
                end
            end
            BK_CROSS_MUL: state_next = BK_CROSS_SUB;
            BK_CROSS_SUB: state_next = BK_NORM_GO;
            BK_DOT_MUL:   state_next = BK_DOT_SUM;
            BK_DOT_SUM:   state_next = (row_reg == ROW_FWD) ? BK_EMIT : BK_DOT_MUL;
            BK_EMIT:
            begin
                if (load_row && row_reg == ROW_LAST)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:      state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop        = (state_reg == BK_IDLE) && head.valid;
        norm_start = (state_reg == BK_NORM_GO);
        load_row   = (state_reg == BK_EMIT) && (!row_valid_reg || !row_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pass_reg      <= PASS_FWD;
            row_reg       <= 2'd0;
            degen_reg     <= 1'b0;
            row_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                BK_IDLE:
                begin
                    pass_reg  <= PASS_FWD;
                    row_reg   <= 2'd0;
                    degen_reg <= 1'b0;
                end
                BK_NORM_WAIT:
                begin
                    if (nres.done && pass_reg != PASS_UP && !nres.nonzero)
                    begin
                        degen_reg <= 1'b1;
                    end
                end
                BK_CROSS_SUB:
                begin
                    pass_reg <= (pass_reg == PASS_FWD) ? PASS_RIGHT : PASS_UP;
                end
                BK_DOT_SUM:
                begin
                    row_reg <= (row_reg == ROW_FWD) ? 2'd0 : row_reg + 2'd1;
                end
                BK_EMIT:
                begin
                    if (load_row)
                    begin
                        row_reg <= row_reg + 2'd1;
                    end
                end
                default:
                begin
                end
            endcase
            if (load_row)
            begin
                row_valid_reg <= 1'b1;
            end
            else if (!row_stall)
            begin
                row_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    pos_reg  <= head.item.pos;
                    hint_reg <= head.item.hint;
                    for (int i = 0; i < 3; i++)
                    begin
                        vec_reg[i] <= VEC_W'($signed(head.item.diff[i]));
                    end
                end
            end
            BK_NORM_WAIT:
            begin
                if (nres.done)
                begin
                    case (pass_reg)
                        PASS_FWD:   f_reg <= nres.unit;
                        PASS_RIGHT: r_reg <= nres.unit;
                        default:    u_reg <= nres.unit;
                    endcase
                end
            end
            BK_CROSS_MUL:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    prod_reg[i] <= cprod[i];
                end
            end
            BK_CROSS_SUB:
            begin
                vec_reg[0] <= VEC_W'(prod_reg[0]) - VEC_W'(prod_reg[1]);
                vec_reg[1] <= VEC_W'(prod_reg[2]) - VEC_W'(prod_reg[3]);
                vec_reg[2] <= VEC_W'(prod_reg[4]) - VEC_W'(prod_reg[5]);
            end
            BK_DOT_MUL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[i] <= dprod[i];
                end
            end
            BK_DOT_SUM:
            begin
                trans_reg[row_reg] <= tval;
            end
            default:
            begin
            end
        endcase
        if (load_row)
        begin
            row_index_reg  <= row_reg;
            degenerate_reg <= degen_reg;
            last_row_reg   <= (row_reg == ROW_LAST);
            for (int i = 0; i < 4; i++)
            begin
                col_reg[i] <= degen_reg ? '0 : nc[i];
            end
        end
    end

    assign row_valid  = row_valid_reg;
    assign row_index  = row_index_reg;
    assign col0       = col_reg[0];
    assign col1       = col_reg[1];
    assign col2       = col_reg[2];
    assign col3       = col_reg[3];
    assign degenerate = degenerate_reg;
    assign last_row   = last_row_reg;

endmodule

// File: design/look_at_view_matrix.sv
// The back end takes one item at a time through the shared normalizer
// (31-step square root and 17-step divide, run three times per item).
// The four rows of an item leave one per cycle when not stalled; a two-entry queue
// takes new items while the back end works. Reset: asynchronous, active low, clears
// the queue, the sequencers and the output valid; no clearing pass.
module look_at_view_matrix (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    input  logic signed [31:0]   pos_z,
    input  logic signed [31:0]   tgt_x,
    input  logic signed [31:0]   tgt_y,
    input  logic signed [31:0]   tgt_z,
    input  logic signed [31:0]   uphint_x,
    input  logic signed [31:0]   uphint_y,
    input  logic signed [31:0]   uphint_z,
    output logic                 row_valid,
    input  logic                 row_stall,
    output logic [1:0]           row_index,
    output logic signed [31:0]   col0,
    output logic signed [31:0]   col1,
    output logic signed [31:0]   col2,
    output logic signed [31:0]   col3,
    output logic                 degenerate,
    output logic                 last_row
);
    import lav_pkg::*;

    coord_vec_t  pos_v;
    coord_vec_t  tgt_v;
    coord_vec_t  hint_v;
    queue_head_t head;
    logic        pop;
    coord_t      c0;
    coord_t      c1;
    coord_t      c2;
    coord_t      c3;

    assign pos_v  = {pos_z, pos_y, pos_x};
    assign tgt_v  = {tgt_z, tgt_y, tgt_x};
    assign hint_v = {uphint_z, uphint_y, uphint_x};

    lav_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .pos        (pos_v),
        .tgt        (tgt_v),
        .hint       (hint_v),
        .head       (head),
        .pop        (pop)
    );

    lav_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .row_valid  (row_valid),
        .row_stall  (row_stall),
        .row_index  (row_index),
        .col0       (c0),
        .col1       (c1),
        .col2       (c2),
        .col3       (c3),
        .degenerate (degenerate),
        .last_row   (last_row)
    );

    assign col0 = $signed(c0);
    assign col1 = $signed(c1);
    assign col2 = $signed(c2);
    assign col3 = $signed(c3);

endmodule

// File: design/lav_checker.sv
module lav_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic [31:0] pos_x,
    input logic [31:0] pos_y,
    input logic [31:0] pos_z,
    input logic [31:0] tgt_x,
    input logic [31:0] tgt_y,
    input logic [31:0] tgt_z,
    input logic [31:0] uphint_x,
    input logic [31:0] uphint_y,
    input logic [31:0] uphint_z,
    input logic        row_valid,
    input logic        row_stall,
    input logic [1:0]  row_index,
    input logic [31:0] col0,
    input logic [31:0] col1,
    input logic [31:0] col2,
    input logic [31:0] col3,
    input logic        degenerate,
    input logic        last_row
);
    import lav_pkg::*;

    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_stall |=> row_valid && $stable(row_index) && $stable(col3))
        else $error("stalled row changed");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> (last_row == (row_index == ROW_LAST)))
        else $error("last_row mark does not match row index");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && degenerate |->
            col0 == 32'd0 && col1 == 32'd0 && col2 == 32'd0 && col3 == 32'd0)
        else $error("degenerate row is not zero");

    a_bottom_row: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !degenerate && last_row |->
            col0 == 32'd0 && col1 == 32'd0 && col2 == 32'd0 && col3 == ONE)
        else $error("bottom row is not 0 0 0 1");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (.*);

// File: verif/look_at_view_matrix_test.sv
module look_at_view_matrix_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lav_pkg::*;

    typedef longint vec3_t [3];

    typedef struct packed {
        logic [1:0]  idx;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
        logic        degen;
        logic        last;
    } view_row_t;

    class view_matrix_board;
        view_row_t pending_rows[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function longint unsigned magnitude(longint v);
            return (v < 0) ? longint'(0) - v : v;
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= res + b)
                begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function bit unitize(vec3_t v, output vec3_t o);
            longint unsigned m[3];
            longint unsigned mx;
            longint unsigned sum;
            longint unsigned len;
            longint unsigned q;
            int msb;
            mx = 0;
            sum = 0;
            msb = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = magnitude(v[i]);
                if (m[i] > mx)
                    mx = m[i];
            end
            if (mx == 0)
            begin
                o = '{0, 0, 0};
                return 0;
            end
            while (msb < 63 && (mx >> (msb + 1)) != 0)
                msb++;
            for (int i = 0; i < 3; i++)
            begin
                if (msb > TOP_BIT)
                    m[i] = m[i] >> (msb - TOP_BIT);
                else
                    m[i] = m[i] << (TOP_BIT - msb);
                sum += m[i] * m[i];
            end
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                q = ((m[i] << FRAC_BITS) + len / 2) / len;
                o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
            end
            return 1;
        endfunction

        function vec3_t cross_prod(vec3_t a, vec3_t b);
            vec3_t o;
            o[0] = a[1] * b[2] - a[2] * b[1];
            o[1] = a[2] * b[0] - a[0] * b[2];
            o[2] = a[0] * b[1] - a[1] * b[0];
            return o;
        endfunction

        function logic [31:0] offset(vec3_t a, vec3_t p, bit neg);
            longint d;
            longint unsigned q;
            longint r;
            d = a[0] * p[0] + a[1] * p[1] + a[2] * p[2];
            q = (magnitude(d) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            r = (d < 0) ? -longint'(q) : longint'(q);
            if (neg)
                r = -r;
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            return r[31:0];
        endfunction

        function void add_camera(logic [31:0] fld [9]);
            vec3_t p, h, d, f, r, u, t;
            bit degen;
            view_row_t row;
            logic [31:0] el [4][4];
            for (int i = 0; i < 3; i++)
            begin
                p[i] = longint'($signed(fld[i]));
                d[i] = longint'($signed(fld[3 + i])) - p[i];
                h[i] = longint'($signed(fld[6 + i]));
            end
            degen = !unitize(d, f);
            t = cross_prod(f, h);
            if (!unitize(t, r))
                degen = 1;
            t = cross_prod(r, f);
            void'(unitize(t, u));
            for (int i = 0; i < 3; i++)
            begin
                el[0][i] = r[i][31:0];
                el[1][i] = u[i][31:0];
                el[2][i] = 32'(-f[i]);
                el[3][i] = 32'd0;
            end
            el[0][3] = offset(r, p, 1);
            el[1][3] = offset(u, p, 1);
            el[2][3] = offset(f, p, 0);
            el[3][3] = 32'd1 << FRAC_BITS;
            for (int k = 0; k < 4; k++)
            begin
                row.idx   = 2'(k);
                row.c0    = degen ? 32'd0 : el[k][0];
                row.c1    = degen ? 32'd0 : el[k][1];
                row.c2    = degen ? 32'd0 : el[k][2];
                row.c3    = degen ? 32'd0 : el[k][3];
                row.degen = degen;
                row.last  = (k == 3);
                pending_rows.push_back(row);
            end
        endfunction

        function void field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_row(view_row_t got);
            view_row_t want;
            if (pending_rows.size() == 0)
            begin
                $display("%0t: unexpected row, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_rows.pop_front();
            field("row_index", 32'(want.idx), 32'(got.idx));
            field("col0", want.c0, got.c0);
            field("col1", want.c1, got.c1);
            field("col2", want.c2, got.c2);
            field("col3", want.c3, got.c3);
            field("degenerate", 32'(want.degen), 32'(got.degen));
            field("last_row", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 800;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] PMAX = 32'h7fff_ffff;
    localparam logic [31:0] NMAX = 32'h8000_0000;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    logic [31:0] pos_x, pos_y, pos_z, tgt_x, tgt_y, tgt_z, uphint_x, uphint_y, uphint_z;
    logic row_valid;
    logic row_stall;
    logic [1:0] row_index;
    logic [31:0] col0, col1, col2, col3;
    logic degenerate;
    logic last_row;

    view_matrix_board board;
    bit idling;
    bit hold_request;
    int quiet_cycles;

    look_at_view_matrix dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .tgt_x(tgt_x), .tgt_y(tgt_y), .tgt_z(tgt_z),
        .uphint_x(uphint_x), .uphint_y(uphint_y), .uphint_z(uphint_z),
        .row_valid(row_valid), .row_stall(row_stall),
        .row_index(row_index),
        .col0(col0), .col1(col1), .col2(col2), .col3(col3),
        .degenerate(degenerate), .last_row(last_row)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            board.add_camera('{pos_x, pos_y, pos_z, tgt_x, tgt_y, tgt_z,
                               uphint_x, uphint_y, uphint_z});
        if (rst_n && row_valid && !row_stall)
            board.check_row('{row_index, col0, col1, col2, col3, degenerate, last_row});
        if ((item_valid && !item_stall) || (row_valid && !row_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int burst;
        int hold;
        bit hold_taken;
        burst = 0;
        hold = 0;
        hold_taken = 0;
        row_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                row_stall = 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                row_stall = 1'b1;
            end
            else if (idling && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 18) - 1;
                row_stall = 1'b1;
            end
            else
                row_stall = 1'b0;
        end
    end

    task automatic send_camera(logic [31:0] fld [9]);
        int gap;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            @(negedge clk);
            item_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        {pos_x, pos_y, pos_z} = {fld[0], fld[1], fld[2]};
        {tgt_x, tgt_y, tgt_z} = {fld[3], fld[4], fld[5]};
        {uphint_x, uphint_y, uphint_z} = {fld[6], fld[7], fld[8]};
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    function automatic logic [31:0] narrow_value();
        return $urandom_range(0, 32'h001f_ffff) - 32'h0010_0000;
    endfunction

    initial
    begin
        logic [31:0] fld [9];
        logic [31:0] step [3];
        int mode;
        board = new();
        idling = 1;
        hold_request = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        {pos_x, pos_y, pos_z, tgt_x, tgt_y, tgt_z, uphint_x, uphint_y, uphint_z} = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        send_camera('{0, 0, 0, 0, 0, -ONE, 0, ONE, 0});
        send_camera('{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0});
        send_camera('{0, 0, 0, 0, 0, 5 * ONE, 0, 0, 3 * ONE});
        send_camera('{ONE, 0, 0, 0, ONE, 0, 0, 0, 0});
        send_camera('{PMAX, PMAX, PMAX, NMAX, NMAX, NMAX, PMAX, PMAX, PMAX});
        send_camera('{NMAX, NMAX, NMAX, PMAX, PMAX, PMAX, NMAX, NMAX, NMAX});
        send_camera('{PMAX, NMAX, PMAX, NMAX, PMAX, NMAX, NMAX, NMAX, PMAX});
        send_camera('{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX - 1, ONE, 0, 0});
        send_camera('{NMAX, NMAX, NMAX, NMAX + 1, NMAX, NMAX, 0, 0, NMAX});
        send_camera('{5 * ONE, 7 * ONE, -3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0});
        send_camera('{0, 0, 0, 1, 0, 0, 0, 0, 1});
        send_camera('{-1, -1, -1, 0, 0, 0, -1, 1, -1});
        send_camera('{PMAX, 0, NMAX, 0, PMAX, 0, 1, 1, 1});

        for (int n = 0; n < 320; n++)
        begin
            if (n == 120)
                hold_request = 1;
            if (n == 260)
                idling = 0;
            mode = $urandom_range(0, 19);
            for (int i = 0; i < 9; i++)
                fld[i] = $urandom();
            if (mode >= 12 && mode < 15)
                for (int i = 0; i < 9; i++)
                    fld[i] = narrow_value();
            else if (mode >= 15 && mode < 17)
                for (int i = 0; i < 3; i++)
                    fld[3 + i] = fld[i];
            else if (mode >= 17 && mode < 19)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    step[i] = narrow_value();
                    fld[i] = narrow_value();
                    fld[3 + i] = fld[i] + step[i];
                    fld[6 + i] = (mode == 17) ? step[i] * 3 : -step[i];
                end
            end
            else if (mode == 19)
                for (int i = 6; i < 9; i++)
                    fld[i] = 0;
            send_camera(fld);
        end
        @(negedge clk);
        item_valid = 1'b0;

        while (board.pending_rows.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.pending_rows.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
